// File: hdl/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants and the command format passed from the front end to the
// back end of the run-length byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

  localparam int LITERAL_MAX_DEFAULT = 127;
  localparam int OUT_BYTES_DEFAULT   = 8;
  localparam int CMD_QUEUE_DEPTH     = 4;
  localparam int STEP_CMDS           = 5;

  localparam logic [7:0] RUN_FLAG  = 8'h80;
  localparam logic [7:0] RUN_CAP   = 8'd128;
  localparam logic [7:0] LONE_HDR  = 8'h01;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_LIT,
    CMD_FLUSH
  } cmd_kind_t;

  // For CMD_LIT, data holds the literal byte count and bank the store bank.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        bank;
    logic        fin;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/rle_ram.sv
// ----------------------------------------------------------------------------
// rle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/rle_front.sv
// ----------------------------------------------------------------------------
// rle_front
// Accepts raw bytes, tracks held byte, run and literal state, writes literal
// bytes to the store and issues coding commands one per cycle while cmd_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_front #(
  parameter int LITERAL_MAX = 127
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         in_byte,
  input  wire logic                               in_last,
  output logic                                    cmd_valid,
  input  wire logic                               cmd_ready,
  output rle_pkg::cmd_t                           cmd,
  input  wire logic                               lit_done,
  output logic                                    lit_busy,
  output logic                                    wr_en,
  output logic [$clog2(LITERAL_MAX):0]            wr_addr,
  output logic [7:0]                              wr_data
);

  import rle_pkg::*;

  localparam int CNT_W = $clog2(LITERAL_MAX + 1);
  localparam int IDX_W = $clog2(LITERAL_MAX);

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_HELD,
    MODE_RUN,
    MODE_LIT
  } mode_t;

  mode_t            mode, mode_next;
  logic [7:0]       held, held_next;
  logic [7:0]       run_len, run_next;
  logic [CNT_W-1:0] lit_cnt, lit_next;
  logic             bank, bank_next;
  logic [1:0]       lit_out;
  logic [2:0]       pend_cnt;
  cmd_t             pend [STEP_CMDS];
  cmd_t             lst [STEP_CMDS];
  logic [2:0]       n;
  logic             accept;
  logic             lit_push;

  function automatic cmd_t mk(cmd_kind_t k, logic [7:0] d, logic b, logic f);
    cmd_t c;
    c.kind = k;
    c.data = d;
    c.bank = b;
    c.fin  = f;
    return c;
  endfunction

  assign in_ready  = (pend_cnt == 3'd0) && (lit_out == 2'd0);
  assign accept    = in_valid && in_ready;
  assign cmd_valid = (pend_cnt != 3'd0);
  assign cmd       = pend[0];
  assign lit_push  = cmd_valid && cmd_ready && (pend[0].kind == CMD_LIT);
  assign lit_busy  = (lit_out != 2'd0);

  always_comb begin
    n         = 3'd0;
    for (int i = 0; i < STEP_CMDS; i++) begin
      lst[i] = mk(CMD_BYTE, 8'd0, 1'b0, 1'b0);
    end
    mode_next = mode;
    held_next = held;
    run_next  = run_len;
    lit_next  = lit_cnt;
    bank_next = bank;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = held;
    if (accept) begin
      case (mode)
        MODE_EMPTY: begin
          held_next = in_byte;
          mode_next = MODE_HELD;
        end
        MODE_HELD: begin
          if (in_byte == held) begin
            run_next  = 8'd2;
            mode_next = MODE_RUN;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = {bank, {IDX_W{1'b0}}};
            lit_next  = CNT_W'(1);
            held_next = in_byte;
            mode_next = MODE_LIT;
          end
        end
        MODE_RUN: begin
          if (in_byte == held && run_len < RUN_CAP) begin
            run_next = run_len + 8'd1;
          end else begin
            lst[n] = mk(CMD_BYTE, RUN_FLAG | {1'b0, 7'(run_len - 8'd1)}, 1'b0, in_last);
            n = n + 3'd1;
            lst[n] = mk(CMD_BYTE, held, 1'b0, in_last);
            n = n + 3'd1;
            held_next = in_byte;
            run_next  = 8'd0;
            mode_next = MODE_HELD;
          end
        end
        default: begin
          if (in_byte == held) begin
            lst[n] = mk(CMD_LIT, 8'(lit_cnt), bank, in_last);
            n = n + 3'd1;
            bank_next = ~bank;
            lit_next  = '0;
            run_next  = 8'd2;
            mode_next = MODE_RUN;
          end else if (lit_cnt == CNT_W'(LITERAL_MAX)) begin
            lst[n] = mk(CMD_LIT, 8'(lit_cnt), bank, in_last);
            n = n + 3'd1;
            bank_next = ~bank;
            wr_en     = 1'b1;
            wr_addr   = {~bank, {IDX_W{1'b0}}};
            lit_next  = CNT_W'(1);
            held_next = in_byte;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = {bank, lit_cnt[IDX_W-1:0]};
            lit_next  = lit_cnt + CNT_W'(1);
            held_next = in_byte;
          end
        end
      endcase
      if (in_last) begin
        if (mode_next == MODE_RUN) begin
          lst[n] = mk(CMD_BYTE, RUN_FLAG | {1'b0, 7'(run_next - 8'd1)}, 1'b0, 1'b1);
          n = n + 3'd1;
          lst[n] = mk(CMD_BYTE, held_next, 1'b0, 1'b1);
          n = n + 3'd1;
        end else begin
          if (mode_next == MODE_LIT) begin
            lst[n] = mk(CMD_LIT, 8'(lit_next), bank_next, 1'b1);
            n = n + 3'd1;
            bank_next = ~bank_next;
          end
          lst[n] = mk(CMD_BYTE, LONE_HDR, 1'b0, 1'b1);
          n = n + 3'd1;
          lst[n] = mk(CMD_BYTE, held_next, 1'b0, 1'b1);
          n = n + 3'd1;
        end
        lst[n] = mk(CMD_FLUSH, 8'd0, 1'b0, 1'b1);
        n = n + 3'd1;
        mode_next = MODE_EMPTY;
        held_next = 8'd0;
        run_next  = 8'd0;
        lit_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_EMPTY;
      held     <= 8'd0;
      run_len  <= 8'd0;
      lit_cnt  <= '0;
      bank     <= 1'b0;
      lit_out  <= 2'd0;
      pend_cnt <= 3'd0;
      for (int i = 0; i < STEP_CMDS; i++) begin
        pend[i] <= mk(CMD_BYTE, 8'd0, 1'b0, 1'b0);
      end
    end else begin
      mode    <= mode_next;
      held    <= held_next;
      run_len <= run_next;
      lit_cnt <= lit_next;
      bank    <= bank_next;
      lit_out <= lit_out + {1'b0, lit_push} - {1'b0, lit_done};
      if (accept) begin
        pend     <= lst;
        pend_cnt <= n;
      end else if (cmd_valid && cmd_ready) begin
        for (int i = 0; i < STEP_CMDS - 1; i++) begin
          pend[i] <= pend[i + 1];
        end
        pend_cnt <= pend_cnt - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/rle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rle_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               push_ready,
  input  wire rle_pkg::cmd_t din,
  output logic               pop_valid,
  input  wire logic          pop,
  output rle_pkg::cmd_t      dout
);

  import rle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign dout       = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= din;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: hdl/rle_back.sv
// ----------------------------------------------------------------------------
// rle_back
// Carries out coding commands: reads literal bytes from the store, packs
// coded bytes into output words and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_back #(
  parameter int LITERAL_MAX = 127,
  parameter int OUT_BYTES   = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire rle_pkg::cmd_t                 cmd,
  output logic                               rd_en,
  output logic [$clog2(LITERAL_MAX):0]       rd_addr,
  input  wire logic [7:0]                    rd_data,
  output logic                               lit_done,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [63:0]                        out_bytes,
  output logic [3:0]                         out_count,
  output logic                               out_last
);

  import rle_pkg::*;

  localparam int CNT_W  = $clog2(LITERAL_MAX + 1);
  localparam int IDX_W  = $clog2(LITERAL_MAX);
  localparam int FILL_W = $clog2(OUT_BYTES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LRD,
    ST_LWR
  } state_t;

  state_t            state, state_next;
  logic [63:0]       word, word_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              fin, fin_next;
  logic              bank, bank_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic              full, can_push;
  logic              push_en, push_last;
  logic [7:0]        pb;
  logic [63:0]       base_word, put_word;
  logic [FILL_W-1:0] base_fill, put_fill;

  assign full     = (fill == FILL_W'(OUT_BYTES));
  assign can_push = !out_valid || out_ready;
  assign pb       = (state == ST_LWR) ? rd_data : cmd.data;
  assign rd_addr  = {bank, idx};

  always_comb begin
    base_word = full ? 64'd0 : word;
    base_fill = full ? '0 : fill;
    put_word  = base_word;
    for (int i = 0; i < 8; i++) begin
      if (i < OUT_BYTES && base_fill == FILL_W'(i)) begin
        put_word[63 - 8 * i -: 8] = pb;
      end
    end
    put_fill = base_fill + FILL_W'(1);
  end

  always_comb begin
    state_next = state;
    word_next  = word;
    fill_next  = fill;
    fin_next   = fin;
    bank_next  = bank;
    idx_next   = idx;
    rem_next   = rem;
    push_en    = 1'b0;
    push_last  = 1'b0;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    lit_done   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (full && !fin) begin
          if (can_push) begin
            push_en   = 1'b1;
            word_next = 64'd0;
            fill_next = '0;
          end
        end else if (cmd_valid && (can_push || (!full && cmd.kind != CMD_FLUSH))) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            CMD_FLUSH: begin
              push_en   = 1'b1;
              push_last = 1'b1;
              word_next = 64'd0;
              fill_next = '0;
              fin_next  = 1'b0;
            end
            CMD_LIT: begin
              push_en    = full;
              word_next  = put_word;
              fill_next  = put_fill;
              fin_next   = cmd.fin;
              bank_next  = cmd.bank;
              idx_next   = '0;
              rem_next   = cmd.data[CNT_W-1:0];
              state_next = ST_LRD;
            end
            default: begin
              push_en   = full;
              word_next = put_word;
              fill_next = put_fill;
              fin_next  = cmd.fin;
            end
          endcase
        end
      end
      ST_LRD: begin
        rd_en      = 1'b1;
        state_next = ST_LWR;
      end
      ST_LWR: begin
        if (!full || can_push) begin
          push_en   = full;
          word_next = put_word;
          fill_next = put_fill;
          idx_next  = idx + IDX_W'(1);
          rem_next  = rem - CNT_W'(1);
          if (rem == CNT_W'(1)) begin
            lit_done   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_LRD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      word      <= 64'd0;
      fill      <= '0;
      fin       <= 1'b0;
      bank      <= 1'b0;
      idx       <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
      out_bytes <= 64'd0;
      out_count <= 4'd0;
      out_last  <= 1'b0;
    end else begin
      state <= state_next;
      word  <= word_next;
      fill  <= fill_next;
      fin   <= fin_next;
      bank  <= bank_next;
      idx   <= idx_next;
      rem   <= rem_next;
      if (push_en) begin
        out_valid <= 1'b1;
        out_bytes <= word;
        out_count <= 4'(fill);
        out_last  <= push_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/run_length_byte_encoder.sv
// Throughput: 1 item/cycle while no chunk is coded and no literal is outstanding; an item
// that codes chunks stalls the input until all its commands are queued, and after a literal
// command, acceptance waits until the back end has read all its bytes from the literal store.
// Reset: synchronous rst clears coder, queue and packer; literal store is not cleared.
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// Byte run-length encoder: front end classifies bytes into run and literal
// chunks, a command queue decouples it from the back end that packs coded
// bytes into output words.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_byte_encoder #(
  parameter int LITERAL_MAX = rle_pkg::LITERAL_MAX_DEFAULT,
  parameter int OUT_BYTES   = rle_pkg::OUT_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte [7:0]
  input  wire logic        s_tlast,   // in_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // out_bytes [63:0], out_count [67:64], zero [71:68]
  output logic             m_tlast    // out_last
);

  import rle_pkg::*;

  localparam int IDX_W     = $clog2(LITERAL_MAX);
  localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

  cmd_t             front_cmd, back_cmd;
  logic             front_cmd_valid, front_cmd_ready;
  logic             back_cmd_valid, back_cmd_ready;
  logic             lit_done, lit_busy;
  logic             wr_en, rd_en;
  logic [IDX_W:0]   wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  logic [63:0]      out_bytes;
  logic [3:0]       out_count;

  rle_front #(
    .LITERAL_MAX (LITERAL_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .cmd_valid (front_cmd_valid),
    .cmd_ready (front_cmd_ready),
    .cmd       (front_cmd),
    .lit_done  (lit_done),
    .lit_busy  (lit_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  rle_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (front_cmd_valid),
    .push_ready (front_cmd_ready),
    .din        (front_cmd),
    .pop_valid  (back_cmd_valid),
    .pop        (back_cmd_ready),
    .dout       (back_cmd)
  );

  rle_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rle_back #(
    .LITERAL_MAX (LITERAL_MAX),
    .OUT_BYTES   (OUT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_cmd_valid),
    .cmd_ready (back_cmd_ready),
    .cmd       (back_cmd),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .lit_done  (lit_done),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'd0, out_count, out_bytes};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count != 4'd0 && out_count <= 4'(OUT_BYTES)))
    else $error("output word lane count out of range");

  a_lit_done_owned: assert property (@(posedge clk) disable iff (rst)
    lit_done |-> lit_busy)
    else $error("literal drain finished with no literal outstanding");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !lit_busy)
    else $error("item accepted while literal store is being read");
`endif

endmodule

`default_nettype wire

// File: bench/tb_run_length_byte_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_run_length_byte_encoder
// Self-checking bench for the run-length byte encoder. Blocks of raw bytes go
// in over the slave stream; a behavioral coder predicts every packed output
// word, and each word taken from the master stream is compared field by field
// with the oldest prediction. Directed blocks hit the single byte, short runs
// and literals; long blocks reach both chunk caps; random blocks mix the rest
// while both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_run_length_byte_encoder;

  localparam int OUT_LANES   = rle_pkg::OUT_BYTES_DEFAULT;
  localparam int LIT_MAX     = rle_pkg::LITERAL_MAX_DEFAULT;
  localparam int RUN_MAX     = 128;
  localparam int ITEM_TARGET = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;
  localparam int STUCK_LIMIT = 4000;

  typedef enum int {CODER_EMPTY, CODER_HELD, CODER_RUN, CODER_LIT} coder_mode_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
  } coded_word_t;

  class coded_word_check;
    coded_word_t  words_due[$];
    int unsigned  fails;
    coder_mode_t  mode;
    logic [7:0]   held;
    int           run_len;
    int           lit_count;
    logic [7:0]   lit_store [LIT_MAX];
    logic [63:0]  word;
    int           fill;

    function new();
      clear_coder();
      word  = '0;
      fill  = 0;
      fails = 0;
    endfunction

    function void clear_coder();
      mode      = CODER_EMPTY;
      held      = '0;
      run_len   = 0;
      lit_count = 0;
    endfunction

    function void push_word(logic last);
      coded_word_t w;
      w.bytes = word;
      w.count = 4'(fill);
      w.last  = last;
      words_due.push_back(w);
      word = '0;
      fill = 0;
    endfunction

    function void pack_byte(logic [7:0] b);
      if (fill >= OUT_LANES) push_word(1'b0);
      word |= {56'b0, b} << (56 - 8 * fill);
      fill++;
    endfunction

    function void code_run();
      pack_byte(rle_pkg::RUN_FLAG | 8'(run_len - 1));
      pack_byte(held);
    endfunction

    function void code_literal();
      pack_byte(8'(lit_count));
      for (int k = 0; k < lit_count; k++) pack_byte(lit_store[k]);
      lit_count = 0;
    endfunction

    // Advance the coder by one input transaction and queue the words it completes.
    function void take_byte(logic [7:0] c, logic last);
      case (mode)
        CODER_EMPTY: begin
          held = c;
          mode = CODER_HELD;
        end
        CODER_HELD: begin
          if (c == held) begin
            run_len = 2;
            mode    = CODER_RUN;
          end else begin
            lit_store[0] = held;
            lit_count    = 1;
            held         = c;
            mode         = CODER_LIT;
          end
        end
        CODER_RUN: begin
          if (c == held && run_len < RUN_MAX) begin
            run_len++;
          end else begin
            code_run();
            held    = c;
            run_len = 0;
            mode    = CODER_HELD;
          end
        end
        default: begin
          if (c == held) begin
            code_literal();
            run_len = 2;
            mode    = CODER_RUN;
          end else if (lit_count >= LIT_MAX) begin
            code_literal();
            lit_store[0] = held;
            lit_count    = 1;
            held         = c;
          end else begin
            lit_store[lit_count] = held;
            lit_count++;
            held = c;
          end
        end
      endcase
      if (last) begin
        if (mode == CODER_RUN) begin
          code_run();
        end else begin
          if (mode == CODER_LIT) code_literal();
          pack_byte(rle_pkg::LONE_HDR);
          pack_byte(held);
        end
        push_word(1'b1);
        clear_coder();
      end else if (fill >= OUT_LANES) begin
        push_word(1'b0);
      end
    endfunction

    function void check_word(logic [63:0] bytes, logic [3:0] count, logic last);
      coded_word_t w;
      if (words_due.size() == 0) begin
        fails++;
        $display("%0t: unexpected word bytes=%h count=%0d last=%0b",
                 $time, bytes, count, last);
        return;
      end
      w = words_due.pop_front();
      if (bytes !== w.bytes) begin
        fails++;
        $display("%0t: out_bytes expected %h actual %h", $time, w.bytes, bytes);
      end
      if (count !== w.count) begin
        fails++;
        $display("%0t: out_count expected %0d actual %0d", $time, w.count, count);
      end
      if (last !== w.last) begin
        fails++;
        $display("%0t: out_last expected %0b actual %0b", $time, w.last, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tlast;

  coded_word_check board = new();
  logic [7:0]      block_bytes[$];
  int unsigned     items_sent = 0;
  logic            src_calm   = 1'b0;
  logic            hold_req   = 1'b0;

  run_length_byte_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while (!src_calm && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_byte(b, last);
    items_sent++;
  endtask

  task automatic send_block();
    for (int i = 0; i < block_bytes.size(); i++) begin
      send_item(block_bytes[i], i == block_bytes.size() - 1);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.words_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic build_random_block(input int len);
    logic [7:0] b;
    int         narrow;
    narrow = $urandom_range(1);
    block_bytes.delete();
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < 45) b = block_bytes[i - 1];
      else if (narrow == 1) b = 8'($urandom_range(3));
      else b = 8'($urandom_range(255));
      block_bytes.push_back(b);
    end
  endtask

  task automatic send_random_blocks(input int unsigned until_items);
    while (items_sent < until_items) begin
      build_random_block($urandom_range(1, 24));
      send_block();
    end
  endtask

  // Sink: check each output transaction, then choose tready for the next cycle.
  initial begin
    int unsigned hold_left;
    int unsigned words_seen;
    logic        hold_done;
    hold_left  = 0;
    words_seen = 0;
    hold_done  = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        board.check_word(m_tdata[63:0], m_tdata[67:64], m_tlast);
        words_seen++;
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (words_seen >= 40 && words_seen < 90) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    block_bytes = '{8'h00};
    send_block();
    block_bytes = '{8'hFF};
    send_block();
    block_bytes = '{8'h5A, 8'h5A};
    send_block();
    block_bytes = '{8'h01, 8'h02, 8'h03};
    send_block();
    block_bytes = '{8'h80, 8'h80, 8'h80, 8'h7F};
    send_block();
    block_bytes = '{8'h11, 8'h22, 8'h33, 8'h33, 8'h33};
    send_block();
    block_bytes = '{8'hA5, 8'hA5, 8'h3C, 8'hC3};
    send_block();
    wait_drained();

    send_random_blocks(items_sent + 40);

    // Run past its cap with no source idling.
    src_calm = 1'b1;
    block_bytes.delete();
    for (int i = 0; i < RUN_MAX + 3; i++) block_bytes.push_back(8'hC7);
    block_bytes.push_back(8'h38);
    send_block();
    src_calm = 1'b0;

    send_random_blocks(items_sent + 20);

    // Literal past its cap; stall the sink partway so the queue backs up.
    block_bytes.delete();
    for (int i = 0; i < 200; i++) block_bytes.push_back(8'(i * 7 + 1));
    for (int i = 0; i < block_bytes.size(); i++) begin
      if (i == 100) hold_req = 1'b1;
      send_item(block_bytes[i], i == block_bytes.size() - 1);
    end

    send_random_blocks(ITEM_TARGET);
    wait_drained();

    if (board.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: run_length_byte_encoder.f
hdl/rle_pkg.sv
hdl/rle_ram.sv
hdl/rle_front.sv
hdl/rle_cmd_fifo.sv
hdl/rle_back.sv
hdl/run_length_byte_encoder.sv
bench/tb_run_length_byte_encoder.sv
